>>> sv/lzhc_pkg.sv
// Shared types, constants and command/status bundles of the LZ hash-chain match finder.
package lzhc_pkg;

   // Sizing
   localparam int BUFFER_BYTES_DEF = 65536;
   localparam int BUCKETS          = 65536;
   localparam int BUCKET_BITS      = 16;
   localparam int PREFIX_BYTES     = 3;
   localparam int POS_BITS         = 17;

   // Multiplicative hash of the 3-byte prefix
   localparam logic [31:0] HASH_MULT  = 32'd2654435761;
   localparam int          HASH_SHIFT = 11;
   localparam int          HASH_TAKE  = 16;

   // Register reset values
   localparam logic [16:0] MAX_MATCH_RESET = 17'd258;
   localparam logic [16:0] WINDOW_RESET    = 17'd32768;

   // Register indexes on the CSR channel
   localparam logic [1:0] CSR_INPUT_LENGTH = 2'd0;
   localparam logic [1:0] CSR_MAX_MATCH    = 2'd1;
   localparam logic [1:0] CSR_WINDOW       = 2'd2;

   typedef enum logic [1:0] {
      OP_LOAD    = 2'd0,
      OP_FIND    = 2'd1,
      OP_ADVANCE = 2'd2,
      OP_RESTART = 2'd3
   } opcode_type;

   // Byte buffer read port usage
   typedef enum logic [1:0] {
      BR_NONE,
      BR_HASH01,
      BR_HASH2,
      BR_CMP
   } byte_rd_type;

   typedef enum logic [4:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DECODE,
      ST_ADV_LOOP,
      ST_H_RD01,
      ST_H_RD2,
      ST_H_KEY,
      ST_H_MUL,
      ST_H_HEAD,
      ST_H_USE,
      ST_WALK,
      ST_PFX_RD,
      ST_PFX_TEST,
      ST_BEST_RD,
      ST_BEST_TEST,
      ST_EXT_CHK,
      ST_EXT_TEST,
      ST_FINISH,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic        accept;
      logic        load_write;
      logic        clr_start;
      logic        clr_step;
      logic        exp_zero;
      logic        exp_bad;
      logic        exp_end;
      logic        c_init;
      logic        c_inc;
      byte_rd_type byte_rd;
      logic        cap01;
      logic        cap2;
      logic        mul;
      logic        head_rd;
      logic        ins_write;
      logic        f_init;
      logic        entry_load;
      logic        walk_start;
      logic        entry_next;
      logic        off_inc;
      logic        off_best;
      logic        off_three;
      logic        best_upd;
      logic        res_clear;
      logic        rsp_load;
   } cmd_type;

   typedef struct packed {
      opcode_type op;
      logic       clr_last;
      logic       adv_bad;
      logic       find_bad;
      logic       c_done;
      logic       c_skip;
      logic       walk_stop;
      logic       byte_eq;
      logic       off_two;
      logic       best_cond;
      logic       off_ge_limit;
      logic       finish_win;
      logic       finish_full;
      logic       rsp_free;
   } status_type;

endpackage

>>> sv/lz_hash_chain_match_finder.sv
// Top level of the LZ hash-chain match finder: sequencer plus datapath.
//
// Items arrive on the req_ stream (opcode in tuser), one result per item leaves
// on the rsp_ stream. Registers are written on the csr_ channel, always ready.
// A load, or a misused advance or find, goes straight to its result; a
// restart runs the clearing pass first. An advance steps through its
// positions and hashes each one that has enough bytes left into its chain.
// A find hashes its prefix and reads the chain head, then tests each chain
// candidate byte by byte (three prefix bytes, an optional probe at the best
// length, then extension); each compare waits for the registered read of
// the byte buffer.
// One item is in work at a time; the next item is taken when the sequencer
// returns to idle, while a finished result may still wait in the output
// register. A full output register holds the sequencer until rsp_tready.
// After reset, and on every restart, a clearing pass writes every chain head
// empty, one bucket a cycle, with req_tready low; the restart result follows
// the pass.
module lz_hash_chain_match_finder #(
   parameter int BUFFER_BYTES = lzhc_pkg::BUFFER_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // position[16:0], end_position[33:17], data_byte[41:34]
   input  logic [1:0]  req_tuser,   // opcode[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // match_distance[16:0], match_length[33:17]
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [16:0] csr_data
);

   lzhc_pkg::cmd_type    cmd;
   lzhc_pkg::status_type st;

   lzhc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .st         (st),
      .cmd        (cmd)
   );

   lzhc_dpath #(
      .BUFFER_BYTES (BUFFER_BYTES)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .cmd        (cmd),
      .st         (st)
   );

endmodule

>>> sv/lzhc_ctrl.sv
// Sequencer of the match finder: decodes items and steps the datapath.
module lzhc_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  lzhc_pkg::status_type st,
   output lzhc_pkg::cmd_type    cmd
);

   lzhc_pkg::state_type state_ff, state_in;
   logic                item_ff, item_in;

   // State and item-pending registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lzhc_pkg::ST_CLEAR;
         item_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         item_ff  <= item_in;
      end
   end

   assign req_tready = (state_ff == lzhc_pkg::ST_IDLE);

   // Next state
   always_comb begin
      state_in = state_ff;
      item_in  = item_ff;
      case (state_ff)
         lzhc_pkg::ST_CLEAR: begin
            if (st.clr_last) state_in = item_ff ? lzhc_pkg::ST_RESP : lzhc_pkg::ST_IDLE;
         end
         lzhc_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               state_in = lzhc_pkg::ST_DECODE;
               item_in  = 1'b1;
            end
         end
         lzhc_pkg::ST_DECODE: begin
            case (st.op)
               lzhc_pkg::OP_LOAD:    state_in = lzhc_pkg::ST_RESP;
               lzhc_pkg::OP_RESTART: state_in = lzhc_pkg::ST_CLEAR;
               lzhc_pkg::OP_ADVANCE:
                  state_in = st.adv_bad ? lzhc_pkg::ST_RESP : lzhc_pkg::ST_ADV_LOOP;
               default:
                  state_in = st.find_bad ? lzhc_pkg::ST_RESP : lzhc_pkg::ST_H_RD01;
            endcase
         end
         lzhc_pkg::ST_ADV_LOOP: begin
            if (st.c_done)      state_in = lzhc_pkg::ST_RESP;
            else if (!st.c_skip) state_in = lzhc_pkg::ST_H_RD01;
         end
         lzhc_pkg::ST_H_RD01: state_in = lzhc_pkg::ST_H_RD2;
         lzhc_pkg::ST_H_RD2:  state_in = lzhc_pkg::ST_H_KEY;
         lzhc_pkg::ST_H_KEY:  state_in = lzhc_pkg::ST_H_MUL;
         lzhc_pkg::ST_H_MUL:  state_in = lzhc_pkg::ST_H_HEAD;
         lzhc_pkg::ST_H_HEAD: state_in = lzhc_pkg::ST_H_USE;
         lzhc_pkg::ST_H_USE: begin
            state_in = (st.op == lzhc_pkg::OP_ADVANCE) ? lzhc_pkg::ST_ADV_LOOP
                                                        : lzhc_pkg::ST_WALK;
         end
         lzhc_pkg::ST_WALK: begin
            state_in = st.walk_stop ? lzhc_pkg::ST_RESP : lzhc_pkg::ST_PFX_RD;
         end
         lzhc_pkg::ST_PFX_RD: state_in = lzhc_pkg::ST_PFX_TEST;
         lzhc_pkg::ST_PFX_TEST: begin
            if (!st.byte_eq)     state_in = lzhc_pkg::ST_WALK;
            else if (!st.off_two) state_in = lzhc_pkg::ST_PFX_RD;
            else if (st.best_cond) state_in = lzhc_pkg::ST_BEST_RD;
            else                  state_in = lzhc_pkg::ST_EXT_CHK;
         end
         lzhc_pkg::ST_BEST_RD: state_in = lzhc_pkg::ST_BEST_TEST;
         lzhc_pkg::ST_BEST_TEST: begin
            state_in = st.byte_eq ? lzhc_pkg::ST_EXT_CHK : lzhc_pkg::ST_WALK;
         end
         lzhc_pkg::ST_EXT_CHK: begin
            state_in = st.off_ge_limit ? lzhc_pkg::ST_FINISH : lzhc_pkg::ST_EXT_TEST;
         end
         lzhc_pkg::ST_EXT_TEST: begin
            state_in = st.byte_eq ? lzhc_pkg::ST_EXT_CHK : lzhc_pkg::ST_FINISH;
         end
         lzhc_pkg::ST_FINISH: begin
            state_in = (st.finish_win && st.finish_full) ? lzhc_pkg::ST_RESP
                                                         : lzhc_pkg::ST_WALK;
         end
         lzhc_pkg::ST_RESP: begin
            if (st.rsp_free) begin
               state_in = lzhc_pkg::ST_IDLE;
               item_in  = 1'b0;
            end
         end
         default: state_in = lzhc_pkg::ST_IDLE;
      endcase
   end

   // Datapath commands
   always_comb begin
      cmd = '0;
      case (state_ff)
         lzhc_pkg::ST_CLEAR: cmd.clr_step = 1'b1;
         lzhc_pkg::ST_IDLE:  cmd.accept = req_tvalid;
         lzhc_pkg::ST_DECODE: begin
            cmd.res_clear = 1'b1;
            case (st.op)
               lzhc_pkg::OP_LOAD: cmd.load_write = 1'b1;
               lzhc_pkg::OP_RESTART: begin
                  cmd.exp_zero  = 1'b1;
                  cmd.clr_start = 1'b1;
               end
               lzhc_pkg::OP_ADVANCE: begin
                  cmd.exp_bad = st.adv_bad;
                  cmd.c_init  = !st.adv_bad;
               end
               default: cmd.f_init = !st.find_bad;
            endcase
         end
         lzhc_pkg::ST_ADV_LOOP: begin
            cmd.exp_end = st.c_done;
            cmd.c_inc   = !st.c_done && st.c_skip;
         end
         lzhc_pkg::ST_H_RD01: cmd.byte_rd = lzhc_pkg::BR_HASH01;
         lzhc_pkg::ST_H_RD2: begin
            cmd.byte_rd = lzhc_pkg::BR_HASH2;
            cmd.cap01   = 1'b1;
         end
         lzhc_pkg::ST_H_KEY:  cmd.cap2 = 1'b1;
         lzhc_pkg::ST_H_MUL:  cmd.mul = 1'b1;
         lzhc_pkg::ST_H_HEAD: cmd.head_rd = 1'b1;
         lzhc_pkg::ST_H_USE: begin
            if (st.op == lzhc_pkg::OP_ADVANCE) begin
               cmd.ins_write = 1'b1;
               cmd.c_inc     = 1'b1;
            end else begin
               cmd.entry_load = 1'b1;
            end
         end
         lzhc_pkg::ST_WALK: cmd.walk_start = !st.walk_stop;
         lzhc_pkg::ST_PFX_RD, lzhc_pkg::ST_BEST_RD: cmd.byte_rd = lzhc_pkg::BR_CMP;
         lzhc_pkg::ST_PFX_TEST: begin
            if (!st.byte_eq)       cmd.entry_next = 1'b1;
            else if (!st.off_two)  cmd.off_inc = 1'b1;
            else if (st.best_cond) cmd.off_best = 1'b1;
            else                   cmd.off_three = 1'b1;
         end
         lzhc_pkg::ST_BEST_TEST: begin
            cmd.off_three  = st.byte_eq;
            cmd.entry_next = !st.byte_eq;
         end
         lzhc_pkg::ST_EXT_CHK: begin
            if (!st.off_ge_limit) cmd.byte_rd = lzhc_pkg::BR_CMP;
         end
         lzhc_pkg::ST_EXT_TEST: cmd.off_inc = st.byte_eq;
         lzhc_pkg::ST_FINISH: begin
            cmd.best_upd   = st.finish_win;
            cmd.entry_next = !(st.finish_win && st.finish_full);
         end
         lzhc_pkg::ST_RESP: cmd.rsp_load = st.rsp_free;
         default: cmd = '0;
      endcase
   end

endmodule

>>> sv/lzhc_dpath.sv
// Datapath of the match finder: registers, byte buffer, chain memories, hash, output register.
module lzhc_dpath #(
   parameter int BUFFER_BYTES = lzhc_pkg::BUFFER_BYTES_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [1:0]           req_tuser,
   input  logic [47:0]          req_tdata,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [1:0]           csr_index,
   input  logic [16:0]          csr_data,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [39:0]          rsp_tdata,
   input  lzhc_pkg::cmd_type    cmd,
   output lzhc_pkg::status_type st
);

   localparam int          AW    = $clog2(BUFFER_BYTES);
   localparam logic [16:0] BUF_W = 17'(BUFFER_BYTES);
   localparam int          BB    = lzhc_pkg::BUCKET_BITS;

   // Memories
   logic [7:0]  byte_mem [BUFFER_BYTES];
   logic [AW:0] head_mem [lzhc_pkg::BUCKETS];
   logic [AW:0] link_mem [BUFFER_BYTES];

   // Config registers
   logic [16:0] in_len_ff, max_len_ff, window_ff;
   logic [16:0] in_len_in, max_len_in, window_in;

   // Item and walk registers
   lzhc_pkg::opcode_type op_ff, op_in;
   logic [16:0] pos_ff, pos_in, nxt_ff, nxt_in, exp_ff, exp_in, c_ff, c_in;
   logic [7:0]  data_ff, data_in, b0_ff, b0_in, b1_ff, b1_in;
   logic [BB-1:0] clr_idx_ff, clr_idx_in, bucket_ff, bucket_in;
   logic [23:0] key_ff, key_in;
   logic [16:0] limit_ff, limit_in, best_d_ff, best_d_in, best_l_ff, best_l_in;
   logic [16:0] steps_ff, steps_in, cand_ff, cand_in, dist_ff, dist_in, off_ff, off_in;
   logic [AW:0] entry_ff, entry_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [16:0] rsp_d_ff, rsp_d_in, rsp_l_ff, rsp_l_in;

   // Memory read registers
   logic [7:0]  qa_ff, qb_ff;
   logic [AW:0] head_q_ff, link_q_ff;

   logic [16:0] eff_len, max_eff, base, addr_a, addr_b, ent_pos, len_left;
   logic [23:0] key_cat;
   logic [31:0] prod;

   assign csr_ready  = 1'b1;
   assign eff_len    = (in_len_ff > BUF_W) ? BUF_W : in_len_ff;
   assign max_eff    = (max_len_ff < 17'(lzhc_pkg::PREFIX_BYTES)) ?
                       17'(lzhc_pkg::PREFIX_BYTES) : max_len_ff;
   assign base       = (op_ff == lzhc_pkg::OP_ADVANCE) ? c_ff : pos_ff;
   assign ent_pos    = 17'(entry_ff[AW-1:0]);
   assign len_left   = eff_len - pos_ff;
   assign key_cat    = {qa_ff, b1_ff, b0_ff};
   assign prod       = {8'd0, key_ff} * lzhc_pkg::HASH_MULT;

   // Byte buffer read addresses
   always_comb begin
      addr_a = base;
      addr_b = base + 17'd1;
      case (cmd.byte_rd)
         lzhc_pkg::BR_HASH2: begin
            addr_a = base + 17'd2;
            addr_b = base + 17'd2;
         end
         lzhc_pkg::BR_CMP: begin
            addr_a = pos_ff + off_ff;
            addr_b = cand_ff + off_ff;
         end
         default: begin
            addr_a = base;
            addr_b = base + 17'd1;
         end
      endcase
   end

   // Byte buffer: one write port, two registered read ports
   always_ff @(posedge clock) begin
      if (cmd.load_write && (pos_ff < BUF_W)) byte_mem[pos_ff[AW-1:0]] <= data_ff;
      if (cmd.byte_rd != lzhc_pkg::BR_NONE) begin
         qa_ff <= byte_mem[addr_a[AW-1:0]];
         qb_ff <= byte_mem[addr_b[AW-1:0]];
      end
   end

   // Chain heads: clearing sweep and insertion share the write port
   always_ff @(posedge clock) begin
      if (cmd.clr_step)       head_mem[clr_idx_ff] <= '0;
      else if (cmd.ins_write) head_mem[bucket_ff]  <= {1'b1, c_ff[AW-1:0]};
      if (cmd.head_rd)        head_q_ff <= head_mem[bucket_ff];
   end

   // Chain links
   always_ff @(posedge clock) begin
      if (cmd.ins_write)  link_mem[c_ff[AW-1:0]] <= head_q_ff;
      if (cmd.walk_start) link_q_ff <= link_mem[entry_ff[AW-1:0]];
   end

   // Next values
   always_comb begin
      in_len_in    = in_len_ff;
      max_len_in   = max_len_ff;
      window_in    = window_ff;
      op_in        = op_ff;
      pos_in       = pos_ff;
      nxt_in       = nxt_ff;
      data_in      = data_ff;
      exp_in       = exp_ff;
      c_in         = c_ff;
      b0_in        = b0_ff;
      b1_in        = b1_ff;
      clr_idx_in   = clr_idx_ff;
      bucket_in    = bucket_ff;
      key_in       = key_ff;
      limit_in     = limit_ff;
      best_d_in    = best_d_ff;
      best_l_in    = best_l_ff;
      steps_in     = steps_ff;
      cand_in      = cand_ff;
      dist_in      = dist_ff;
      off_in       = off_ff;
      entry_in     = entry_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_d_in     = rsp_d_ff;
      rsp_l_in     = rsp_l_ff;

      // CSR writes
      if (csr_valid) begin
         case (csr_index)
            lzhc_pkg::CSR_INPUT_LENGTH: in_len_in  = csr_data;
            lzhc_pkg::CSR_MAX_MATCH:    max_len_in = csr_data;
            lzhc_pkg::CSR_WINDOW:       window_in  = csr_data;
            default: ;
         endcase
      end

      // Item capture
      if (cmd.accept) begin
         op_in   = lzhc_pkg::opcode_type'(req_tuser);
         pos_in  = req_tdata[16:0];
         nxt_in  = req_tdata[33:17];
         data_in = req_tdata[41:34];
      end

      // Expected position and clearing sweep
      if (cmd.exp_zero) exp_in = '0;
      if (cmd.exp_bad)  exp_in = eff_len + 17'd1;
      if (cmd.exp_end)  exp_in = nxt_ff;
      if (cmd.clr_start) clr_idx_in = '0;
      if (cmd.clr_step)  clr_idx_in = clr_idx_ff + 1'b1;

      // Advance position
      if (cmd.c_init) c_in = pos_ff;
      if (cmd.c_inc)  c_in = c_ff + 17'd1;

      // Hash pipeline
      if (cmd.cap01) begin
         b0_in = qa_ff;
         b1_in = qb_ff;
      end
      if (cmd.cap2) key_in = key_cat ^ (key_cat >> lzhc_pkg::HASH_SHIFT);
      if (cmd.mul)  bucket_in = prod[lzhc_pkg::HASH_TAKE +: BB];

      // Find setup and walk
      if (cmd.res_clear) begin
         best_d_in = '0;
         best_l_in = '0;
      end
      if (cmd.f_init) begin
         limit_in = (max_eff < len_left) ? max_eff : len_left;
         steps_in = '0;
      end
      if (cmd.entry_load) entry_in = head_q_ff;
      if (cmd.entry_next) entry_in = link_q_ff;
      if (cmd.walk_start) begin
         cand_in  = ent_pos;
         dist_in  = pos_ff - ent_pos;
         steps_in = steps_ff + 17'd1;
         off_in   = '0;
      end
      if (cmd.off_inc)   off_in = off_ff + 17'd1;
      if (cmd.off_best)  off_in = best_l_ff;
      if (cmd.off_three) off_in = 17'(lzhc_pkg::PREFIX_BYTES);
      if (cmd.best_upd) begin
         best_d_in = dist_ff;
         best_l_in = off_ff;
      end

      // Output register
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_d_in     = best_d_ff;
         rsp_l_in     = best_l_ff;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_len_ff    <= '0;
         max_len_ff   <= lzhc_pkg::MAX_MATCH_RESET;
         window_ff    <= lzhc_pkg::WINDOW_RESET;
         exp_ff       <= '0;
         clr_idx_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_len_ff    <= in_len_in;
         max_len_ff   <= max_len_in;
         window_ff    <= window_in;
         exp_ff       <= exp_in;
         clr_idx_ff   <= clr_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      pos_ff    <= pos_in;
      nxt_ff    <= nxt_in;
      data_ff   <= data_in;
      c_ff      <= c_in;
      b0_ff     <= b0_in;
      b1_ff     <= b1_in;
      bucket_ff <= bucket_in;
      key_ff    <= key_in;
      limit_ff  <= limit_in;
      best_d_ff <= best_d_in;
      best_l_ff <= best_l_in;
      steps_ff  <= steps_in;
      cand_ff   <= cand_in;
      dist_ff   <= dist_in;
      off_ff    <= off_in;
      entry_ff  <= entry_in;
      rsp_d_ff  <= rsp_d_in;
      rsp_l_ff  <= rsp_l_in;
   end

   // Status to the sequencer
   always_comb begin
      st.op           = op_ff;
      st.clr_last     = (clr_idx_ff == {BB{1'b1}});
      st.adv_bad      = (pos_ff != exp_ff) || (nxt_ff < pos_ff) || (nxt_ff > eff_len);
      st.find_bad     = (pos_ff != exp_ff) || (pos_ff >= eff_len) ||
                        (len_left < 17'(lzhc_pkg::PREFIX_BYTES));
      st.c_done       = (c_ff >= nxt_ff);
      st.c_skip       = ((eff_len - c_ff) < 17'(lzhc_pkg::PREFIX_BYTES)) || (c_ff >= BUF_W);
      st.walk_stop    = !entry_ff[AW] || (steps_ff == BUF_W) || (ent_pos >= pos_ff) ||
                        ((pos_ff - ent_pos) > window_ff);
      st.byte_eq      = (qa_ff == qb_ff);
      st.off_two      = (off_ff == 17'(lzhc_pkg::PREFIX_BYTES - 1));
      st.best_cond    = (best_l_ff != '0) && (best_l_ff != limit_ff);
      st.off_ge_limit = (off_ff >= limit_ff);
      st.finish_win   = (off_ff > best_l_ff);
      st.finish_full  = (off_ff == limit_ff);
      st.rsp_free     = !rsp_valid_ff || rsp_tready;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, rsp_l_ff, rsp_d_ff};

endmodule
